// ===== hw/rtl/yab_pkg.sv =====
package yab_pkg;

  // fixed field widths
  localparam int PIX_W      = 8;
  localparam int ALPHA_W    = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLEND_MODE = 1'd1;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 9'd128;

  // blend weights are in 256ths
  localparam int WEIGHT_SHIFT = 8;
  localparam int WEIGHT_ONE   = 256;

  // rgb after conversion stays inside +/-1023
  localparam int RGB_W  = 11;
  // weight times rgb, and the sum of two of them
  localparam int PROD_W = 22;
  // blended rgb stays inside +/-4095
  localparam int MIX_W  = 13;

  typedef struct packed {
    logic signed [RGB_W-1:0] r;
    logic signed [RGB_W-1:0] g;
    logic signed [RGB_W-1:0] b;
  } rgb_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] r;
    logic signed [PROD_W-1:0] g;
    logic signed [PROD_W-1:0] b;
  } prod_rgb_t;

  typedef struct packed {
    logic signed [MIX_W-1:0] r;
    logic signed [MIX_W-1:0] g;
    logic signed [MIX_W-1:0] b;
  } mix_t;

endpackage

// ===== hw/rtl/yuv_alpha_blend_pixel.sv =====
// Per-pixel alpha blend of YUV video done in RGB space. Each item carries Y, U and V of
// frame A and frame B plus a chroma-site flag; the block converts both to RGB (truncated
// toward zero), scales A by alpha/256 in fade mode or mixes alpha/256 of A with
// (256-alpha)/256 of B in overlay mode, and converts back to Y and, at chroma sites,
// U and V with the +128 offset. Outputs keep the low 8 bits, no clamping; cb_out and
// cr_out are 0 away from chroma sites. The datapath is four register stages (rgb
// conversion, weight multiply, sum and divide by 256, yuv conversion into the output
// register), which an item passes through in order; one item can be taken every clock
// while in_stall is low. Each stage moves forward whenever the stage after it is
// empty or moving, so bubbles are squeezed out under out_stall and in_stall rises only
// when all four stages hold items. Write alpha and blend_mode only while the pipeline
// is empty; coefficients are held with COEF_FRAC_BITS fraction bits (8 to 16).
module yuv_alpha_blend_pixel
  import yab_pkg::*;
#(
  parameter int COEF_FRAC_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input items
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PIX_W-1:0]      in_luma_a,
  input  logic [PIX_W-1:0]      in_cb_a,
  input  logic [PIX_W-1:0]      in_cr_a,
  input  logic [PIX_W-1:0]      in_luma_b,
  input  logic [PIX_W-1:0]      in_cb_b,
  input  logic [PIX_W-1:0]      in_cr_b,
  input  logic                  in_chroma_site,
  // result items
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PIX_W-1:0]      out_luma_out,
  output logic [PIX_W-1:0]      out_cb_out,
  output logic [PIX_W-1:0]      out_cr_out,
  output logic                  out_chroma_valid
);

  localparam int F   = COEF_FRAC_BITS;
  // yuv to rgb sum width
  localparam int S1W = F + 11;
  // rgb to yuv sum width
  localparam int S4W = F + 16;

  // yuv to rgb coefficients, rounded half up from thousandths
  localparam logic signed [S1W-1:0] K_RV = S1W'((1140 * (2 ** F) + 500) / 1000);
  localparam logic signed [S1W-1:0] K_GU = S1W'((394 * (2 ** F) + 500) / 1000);
  localparam logic signed [S1W-1:0] K_GV = S1W'((581 * (2 ** F) + 500) / 1000);
  localparam logic signed [S1W-1:0] K_BU = S1W'((2032 * (2 ** F) + 500) / 1000);

  // rgb to yuv coefficients
  localparam logic signed [S4W-1:0] K_YR = S4W'((299 * (2 ** F) + 500) / 1000);
  localparam logic signed [S4W-1:0] K_YG = S4W'((587 * (2 ** F) + 500) / 1000);
  localparam logic signed [S4W-1:0] K_YB = S4W'((114 * (2 ** F) + 500) / 1000);
  localparam logic signed [S4W-1:0] K_UR = S4W'((147 * (2 ** F) + 500) / 1000);
  localparam logic signed [S4W-1:0] K_UG = S4W'((289 * (2 ** F) + 500) / 1000);
  localparam logic signed [S4W-1:0] K_UB = S4W'((436 * (2 ** F) + 500) / 1000);
  localparam logic signed [S4W-1:0] K_VR = S4W'((615 * (2 ** F) + 500) / 1000);
  localparam logic signed [S4W-1:0] K_VG = S4W'((515 * (2 ** F) + 500) / 1000);
  localparam logic signed [S4W-1:0] K_VB = S4W'((100 * (2 ** F) + 500) / 1000);
  localparam logic signed [S4W-1:0] K_OFF = S4W'(128 * (2 ** F));

  // divide by 2^F toward zero, keep the rgb width
  function automatic logic signed [RGB_W-1:0] rgb_trunc(input logic signed [S1W-1:0] s);
    logic signed [S1W-1:0] q;
    q = s >>> F;
    if (s[S1W-1] && (s[F-1:0] != '0)) begin
      q = q + S1W'(1);
    end
    return q[RGB_W-1:0];
  endfunction

  function automatic rgb_t to_rgb(input logic [PIX_W-1:0] y,
                                  input logic [PIX_W-1:0] u,
                                  input logic [PIX_W-1:0] v);
    logic signed [S1W-1:0] ys;
    logic signed [S1W-1:0] uc;
    logic signed [S1W-1:0] vc;
    rgb_t res;
    ys = S1W'($signed({1'b0, y})) <<< F;
    uc = S1W'($signed({1'b0, u}) - 10'sd128);
    vc = S1W'($signed({1'b0, v}) - 10'sd128);
    res.r = rgb_trunc(ys + K_RV * vc);
    res.g = rgb_trunc(ys - K_GU * uc - K_GV * vc);
    res.b = rgb_trunc(ys + K_BU * uc);
    return res;
  endfunction

  // divide by 256 toward zero
  function automatic logic signed [MIX_W-1:0] mix_trunc(input logic signed [PROD_W-1:0] s);
    logic signed [PROD_W-1:0] q;
    q = s >>> WEIGHT_SHIFT;
    if (s[PROD_W-1] && (s[WEIGHT_SHIFT-1:0] != '0)) begin
      q = q + PROD_W'(1);
    end
    return q[MIX_W-1:0];
  endfunction

  // divide by 2^F toward zero, keep the low 8 bits
  function automatic logic [PIX_W-1:0] pix_trunc(input logic signed [S4W-1:0] s);
    logic signed [S4W-1:0] q;
    q = s >>> F;
    if (s[S4W-1] && (s[F-1:0] != '0)) begin
      q = q + S4W'(1);
    end
    return q[PIX_W-1:0];
  endfunction

  // configuration registers
  logic [ALPHA_W-1:0] alpha_r;
  logic               blend_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r      <= ALPHA_RESET;
      blend_mode_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ALPHA:      alpha_r      <= cfg_data[ALPHA_W-1:0];
        CFG_BLEND_MODE: blend_mode_r <= cfg_data[0];
        default:        ;
      endcase
    end
  end

  // pipeline registers
  logic      s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r;
  logic      s1_site_r, s2_site_r, s3_site_r;
  rgb_t      s1_a_r, s1_b_r;
  rgb_t      s1_a_nxt, s1_b_nxt;
  prod_rgb_t s2_pa_r, s2_pb_r;
  prod_rgb_t s2_pa_nxt, s2_pb_nxt;
  mix_t      s3_mix_r;
  mix_t      s3_mix_nxt;
  logic [PIX_W-1:0] luma_r, cb_r, cr_r;
  logic [PIX_W-1:0] luma_nxt, cb_nxt, cr_nxt;
  logic      chroma_r;

  // per-stage ready chain
  logic out_ready, s3_ready, s2_ready, s1_ready;

  assign out_ready = !out_valid_r || !out_stall;
  assign s3_ready  = !s3_valid_r || out_ready;
  assign s2_ready  = !s2_valid_r || s3_ready;
  assign s1_ready  = !s1_valid_r || s2_ready;
  assign in_stall  = !s1_ready;

  // stage 1: yuv to rgb for both frames
  always_comb begin
    s1_a_nxt = to_rgb(in_luma_a, in_cb_a, in_cr_a);
    s1_b_nxt = to_rgb(in_luma_b, in_cb_b, in_cr_b);
  end

  // stage 2: weight products, frame b drops out in fade mode
  logic signed [PROD_W-1:0] w_a, w_b;

  always_comb begin
    w_a = PROD_W'($signed({1'b0, alpha_r}));
    w_b = PROD_W'(WEIGHT_ONE) - w_a;
    s2_pa_nxt.r = w_a * PROD_W'(s1_a_r.r);
    s2_pa_nxt.g = w_a * PROD_W'(s1_a_r.g);
    s2_pa_nxt.b = w_a * PROD_W'(s1_a_r.b);
    if (blend_mode_r) begin
      s2_pb_nxt.r = w_b * PROD_W'(s1_b_r.r);
      s2_pb_nxt.g = w_b * PROD_W'(s1_b_r.g);
      s2_pb_nxt.b = w_b * PROD_W'(s1_b_r.b);
    end else begin
      s2_pb_nxt = '0;
    end
  end

  // stage 3: mix and divide by 256
  always_comb begin
    s3_mix_nxt.r = mix_trunc(s2_pa_r.r + s2_pb_r.r);
    s3_mix_nxt.g = mix_trunc(s2_pa_r.g + s2_pb_r.g);
    s3_mix_nxt.b = mix_trunc(s2_pa_r.b + s2_pb_r.b);
  end

  // stage 4: rgb back to yuv
  logic signed [S4W-1:0] mr, mg, mb;

  always_comb begin
    mr = S4W'(s3_mix_r.r);
    mg = S4W'(s3_mix_r.g);
    mb = S4W'(s3_mix_r.b);
    luma_nxt = pix_trunc(K_YR * mr + K_YG * mg + K_YB * mb);
    if (s3_site_r) begin
      cb_nxt = pix_trunc(K_UB * mb - K_UR * mr - K_UG * mg + K_OFF);
      cr_nxt = pix_trunc(K_VR * mr - K_VG * mg - K_VB * mb + K_OFF);
    end else begin
      cb_nxt = '0;
      cr_nxt = '0;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end
      if (s3_ready) begin
        s3_valid_r <= s2_valid_r;
      end
      if (out_ready) begin
        out_valid_r <= s3_valid_r;
      end
    end
  end

  // payload, loaded only when an item moves in
  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_a_r    <= s1_a_nxt;
      s1_b_r    <= s1_b_nxt;
      s1_site_r <= in_chroma_site;
    end
    if (s2_ready && s1_valid_r) begin
      s2_pa_r   <= s2_pa_nxt;
      s2_pb_r   <= s2_pb_nxt;
      s2_site_r <= s1_site_r;
    end
    if (s3_ready && s2_valid_r) begin
      s3_mix_r  <= s3_mix_nxt;
      s3_site_r <= s2_site_r;
    end
    if (out_ready && s3_valid_r) begin
      luma_r   <= luma_nxt;
      cb_r     <= cb_nxt;
      cr_r     <= cr_nxt;
      chroma_r <= s3_site_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_luma_out     = luma_r;
  assign out_cb_out       = cb_r;
  assign out_cr_out       = cr_r;
  assign out_chroma_valid = chroma_r;

  // chroma fields are zero away from chroma sites
  a_chroma_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !chroma_r |-> (cb_r == '0) && (cr_r == '0))
    else $error("chroma fields nonzero away from chroma site");

  // input backs up only with every stage occupied
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && s2_valid_r && s3_valid_r && out_valid_r)
    else $error("input stalled with a free stage");

  // a blocked mix stage keeps its item
  a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s3_valid_r && !s3_ready |=> s3_valid_r && $stable(s3_mix_r) && $stable(s3_site_r))
    else $error("mix stage lost its item under stall");

  // an item leaving the mix stage lands in the output register
  a_s3_advance: assert property (@(posedge clk) disable iff (!rst_n)
    s3_valid_r && out_ready |=> out_valid_r)
    else $error("item dropped between mix stage and output");

endmodule
